[src/k_way_sorted_merge_core_defines.svh]
// Assertion macros for the k-way sorted merge core.
`ifndef K_WAY_SORTED_MERGE_CORE_DEFINES_SVH
`define K_WAY_SORTED_MERGE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define KWSM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kwsm: same-cycle check failed");
// Next-cycle implication.
`define KWSM_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kwsm: next-cycle check failed");
`else
`define KWSM_ASSERT_IMP(label, clk, rst, ante, cons)
`define KWSM_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

[src/kwsm_pkg.sv]
// Shared constants, types and helpers of the k-way sorted merge core.
package kwsm_pkg;

   localparam int NUM_LANES  = 8;
   localparam int LANE_DEPTH = 64;
   localparam int DATA_W     = 32;

   localparam int LANE_W    = $clog2(NUM_LANES);
   localparam int PTR_W     = (LANE_DEPTH > 1) ? $clog2(LANE_DEPTH) : 1;
   localparam int CNT_W     = $clog2(LANE_DEPTH + 1);
   localparam int MEM_DEPTH = NUM_LANES * LANE_DEPTH;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);

   typedef enum logic [1:0] {
      OP_APPEND = 2'd0,
      OP_POP    = 2'd1,
      OP_CLEAR  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      STS_OK    = 2'd0,
      STS_FULL  = 2'd1,
      STS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_TAIL,
      S_UPDATE,
      S_DONE
   } state_type;

   // Flat store address of a lane slot.
   function automatic logic [ADDR_W-1:0] slot_addr(input logic [LANE_W-1:0] lane,
                                                   input logic [PTR_W-1:0] slot);
      return ADDR_W'(lane) * ADDR_W'(LANE_DEPTH) + ADDR_W'(slot);
   endfunction

endpackage

[src/k_way_sorted_merge_core.sv]
// k-way sorted merge core: lane FIFOs in one RAM, lowest-head pop by a serial scan.
// Append, clear and unused opcodes go S_EXEC then S_DONE; a pop walks S_SCAN over every lane,
// then S_TAIL, S_UPDATE and S_DONE, set by the single RAM read port and the one comparator
// walking the lane heads one lane a cycle. No new beat is taken until the result has moved
// to the output register, which S_DONE waits for while that register is full and stalled.
// Reset (synchronous) empties every lane; the lane store itself is not cleared.
`include "k_way_sorted_merge_core_defines.svh"

module k_way_sorted_merge_core (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_opcode,
   input  logic [2:0]         req_lane,
   input  logic signed [31:0] req_value,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_out_value,
   output logic [2:0]         rsp_out_lane
);

   // ---------------------------------------------------------------
   // Sequencer state and the latched request beat
   // ---------------------------------------------------------------
   kwsm_pkg::state_type state_ff, state_in;

   logic [1:0]                        item_op_ff;
   logic [2:0]                        item_lane_ff;
   logic [kwsm_pkg::DATA_W-1:0]       item_value_ff;

   // Per-lane head pointer and occupancy; one shared index selects the lane.
   logic [kwsm_pkg::PTR_W-1:0] rp_ff   [kwsm_pkg::NUM_LANES];
   logic [kwsm_pkg::CNT_W-1:0] fill_ff [kwsm_pkg::NUM_LANES];
   logic [kwsm_pkg::LANE_W-1:0] sel_idx;
   logic [kwsm_pkg::PTR_W-1:0]  rp_rd, rp_in, ptr_inc, tail_slot;
   logic [kwsm_pkg::CNT_W-1:0]  fill_rd, fill_in;
   logic [kwsm_pkg::CNT_W:0]    tail_sum;
   logic                        cnt_we, clear_all, lane_ok;

   // Scan: lane counter, a read in flight, and the running best head.
   logic [kwsm_pkg::LANE_W-1:0] scan_idx_ff, scan_idx_in;
   logic                        pend_valid_ff, pend_valid_in;
   logic [kwsm_pkg::LANE_W-1:0] pend_lane_ff, pend_lane_in;
   logic                        found_ff;
   logic [kwsm_pkg::LANE_W-1:0] best_lane_ff;
   logic signed [31:0]          best_value_ff;
   logic                        take_head;

   // Lane store RAM
   logic                          ram_we, ram_re;
   logic [kwsm_pkg::ADDR_W-1:0]   ram_waddr, ram_raddr;
   logic [kwsm_pkg::DATA_W-1:0]   ram_rdata;

   // Finished result waiting for the output register, then the output register
   logic                        res_load, rsp_load;
   kwsm_pkg::status_type        res_status_in;
   logic signed [31:0]          res_value_in;
   logic [2:0]                  res_lane_in;
   logic [1:0]                  res_status_ff;
   logic signed [31:0]          res_value_ff;
   logic [2:0]                  res_lane_ff;
   logic                        rsp_valid_ff;
   logic [1:0]                  rsp_status_ff;
   logic signed [31:0]          rsp_value_ff;
   logic [2:0]                  rsp_lane_ff;

   logic req_accept;

   assign req_stall  = (state_ff != kwsm_pkg::S_IDLE);
   assign req_accept = req_valid && !req_stall;

   // ---------------------------------------------------------------
   // Lane bookkeeping for the selected lane
   // ---------------------------------------------------------------
   assign rp_rd   = rp_ff[sel_idx];
   assign fill_rd = fill_ff[sel_idx];
   assign ptr_inc = (rp_rd == kwsm_pkg::PTR_W'(kwsm_pkg::LANE_DEPTH - 1))
                    ? '0 : rp_rd + 1'b1;
   // tail = (head + fill) mod depth; the sum stays below twice the depth
   assign tail_sum  = (kwsm_pkg::CNT_W + 1)'(rp_rd) + (kwsm_pkg::CNT_W + 1)'(fill_rd);
   assign tail_slot = (tail_sum >= (kwsm_pkg::CNT_W + 1)'(kwsm_pkg::LANE_DEPTH))
                      ? kwsm_pkg::PTR_W'(tail_sum - (kwsm_pkg::CNT_W + 1)'(kwsm_pkg::LANE_DEPTH))
                      : kwsm_pkg::PTR_W'(tail_sum);
   assign lane_ok   = (32'(item_lane_ff) < 32'(kwsm_pkg::NUM_LANES));

   // Shared comparator: head coming back from RAM against the best so far.
   // Strict less-than keeps the lower lane on a tie, since lanes scan upward.
   assign take_head = pend_valid_ff && (!found_ff || ($signed(ram_rdata) < best_value_ff));

   // ---------------------------------------------------------------
   // Sequencer: next state and control
   // ---------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      sel_idx       = scan_idx_ff;
      scan_idx_in   = scan_idx_ff;
      pend_valid_in = 1'b0;
      pend_lane_in  = scan_idx_ff;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      cnt_we        = 1'b0;
      clear_all     = 1'b0;
      rp_in         = rp_rd;
      fill_in       = fill_rd;
      res_load      = 1'b0;
      res_status_in = kwsm_pkg::STS_OK;
      res_value_in  = '0;
      res_lane_in   = '0;
      rsp_load      = 1'b0;

      case (state_ff)
         kwsm_pkg::S_IDLE: begin
            scan_idx_in = '0;
            if (req_accept) begin
               state_in = (req_opcode == kwsm_pkg::OP_POP) ? kwsm_pkg::S_SCAN
                                                          : kwsm_pkg::S_EXEC;
            end
         end
         kwsm_pkg::S_EXEC: begin
            sel_idx  = kwsm_pkg::LANE_W'(item_lane_ff);
            res_load = 1'b1;
            state_in = kwsm_pkg::S_DONE;
            case (item_op_ff)
               kwsm_pkg::OP_APPEND: begin
                  if (!lane_ok || fill_rd >= kwsm_pkg::CNT_W'(kwsm_pkg::LANE_DEPTH)) begin
                     res_status_in = kwsm_pkg::STS_FULL;
                  end else begin
                     ram_we  = 1'b1;
                     cnt_we  = 1'b1;
                     fill_in = fill_rd + 1'b1;
                  end
               end
               kwsm_pkg::OP_CLEAR: begin
                  clear_all = 1'b1;
               end
               default: begin
               end
            endcase
         end
         kwsm_pkg::S_SCAN: begin
            // read this lane's head while the previous one is compared
            if (fill_rd != '0) begin
               ram_re        = 1'b1;
               pend_valid_in = 1'b1;
            end
            if (scan_idx_ff == kwsm_pkg::LANE_W'(kwsm_pkg::NUM_LANES - 1)) begin
               state_in = kwsm_pkg::S_TAIL;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end
         kwsm_pkg::S_TAIL: begin
            // last head compare
            state_in = kwsm_pkg::S_UPDATE;
         end
         kwsm_pkg::S_UPDATE: begin
            sel_idx  = best_lane_ff;
            res_load = 1'b1;
            state_in = kwsm_pkg::S_DONE;
            if (found_ff) begin
               cnt_we       = 1'b1;
               rp_in        = ptr_inc;
               fill_in      = fill_rd - 1'b1;
               res_value_in = best_value_ff;
               res_lane_in  = 3'(best_lane_ff);
            end else begin
               res_status_in = kwsm_pkg::STS_EMPTY;
            end
         end
         kwsm_pkg::S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = kwsm_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = kwsm_pkg::S_IDLE;
         end
      endcase
   end

   assign ram_waddr = kwsm_pkg::slot_addr(sel_idx, tail_slot);
   assign ram_raddr = kwsm_pkg::slot_addr(sel_idx, rp_rd);

   kwsm_ram #(
      .DATA_W (kwsm_pkg::DATA_W),
      .DEPTH  (kwsm_pkg::MEM_DEPTH)
   ) u_lane_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (item_value_ff),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // ---------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= kwsm_pkg::S_IDLE;
         scan_idx_ff   <= '0;
         pend_valid_ff <= 1'b0;
         found_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scan_idx_ff   <= scan_idx_in;
         pend_valid_ff <= pend_valid_in;
         if (req_accept) begin
            found_ff <= 1'b0;
         end else if (take_head) begin
            found_ff <= 1'b1;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // lane pointers and counts
   always_ff @(posedge clock) begin
      if (reset || clear_all) begin
         for (int i = 0; i < kwsm_pkg::NUM_LANES; i++) begin
            rp_ff[i]   <= '0;
            fill_ff[i] <= '0;
         end
      end else if (cnt_we) begin
         rp_ff[sel_idx]   <= rp_in;
         fill_ff[sel_idx] <= fill_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_op_ff    <= req_opcode;
         item_lane_ff  <= req_lane;
         item_value_ff <= req_value;
      end
      pend_lane_ff <= pend_lane_in;
      if (take_head) begin
         best_lane_ff  <= pend_lane_ff;
         best_value_ff <= $signed(ram_rdata);
      end
      if (res_load) begin
         res_status_ff <= res_status_in;
         res_value_ff  <= res_value_in;
         res_lane_ff   <= res_lane_in;
      end
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_value_ff  <= res_value_ff;
         rsp_lane_ff   <= res_lane_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_out_lane  = rsp_lane_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   // an accepted beat always starts work
   `KWSM_ASSERT_NXT(a_accept_starts, clock, reset, req_accept, state_ff != kwsm_pkg::S_IDLE)
   // a finished result moves to a free output register right away
   `KWSM_ASSERT_NXT(a_done_loads, clock, reset,
      (state_ff == kwsm_pkg::S_DONE) && (!rsp_valid_ff || !rsp_stall), rsp_valid)
   // scanned lanes never hold more than the lane depth
   `KWSM_ASSERT_IMP(a_fill_bound, clock, reset, state_ff == kwsm_pkg::S_SCAN,
      fill_rd <= kwsm_pkg::CNT_W'(kwsm_pkg::LANE_DEPTH))
   // an empty pop carries zero payload
   `KWSM_ASSERT_IMP(a_empty_zero, clock, reset,
      rsp_valid && (rsp_status == kwsm_pkg::STS_EMPTY),
      (rsp_out_value == '0) && (rsp_out_lane == '0))

endmodule

[src/kwsm_ram.sv]
// Simple dual-port RAM, one write and one registered read port.
module kwsm_ram #(
   parameter int DATA_W = 32,
   parameter int DEPTH  = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
